### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the RC4 keystream generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, switched off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication on clk: when cond holds, res must hold in the same cycle.
`define ASSERT_IMPL(label, cond, res, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (res)) \
		else $error(msg);

`endif

### rtl/rc4_pkg.sv
// Package with the types, codes and constants of the RC4 keystream generator.
package rc4_pkg;

	localparam int unsigned PERM_DEPTH = 256;
	localparam int unsigned IDX_W      = $clog2(PERM_DEPTH);
	localparam int unsigned BYTE_W     = 8;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// Item modes; the fourth code is unused and ignored.
	typedef enum logic [1:0] {
		MODE_RESTART = 2'd0,
		MODE_KEY     = 2'd1,
		MODE_GEN     = 2'd2
	} mode_t;

	// Sequencer states of one item.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_SWAP,
		ST_HOLD
	} state_t;

	// Access request from the sequencer to the permutation memory.
	typedef struct packed {
		logic  clear;
		logic  wr_en;
		idx_t  wr_addr;
		byte_t wr_data;
		idx_t  rd_addr;
	} mem_req_t;

endpackage

### rtl/rc4_perm_mem.sv
// Permutation memory with per-entry valid bits and same-cycle write forwarding.
module rc4_perm_mem import rc4_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output byte_t    rd_data
);

	byte_t               mem_q [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] valid_q;

	byte_t rd_raw_s1;
	idx_t  rd_addr_s1;
	logic  rd_valid_s1;
	logic  hit_s1;
	byte_t hit_data_s1;

	// Storage array: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_raw_s1 <= mem_q[req.rd_addr];
	end

	// Valid bits: an entry never written since restart reads as its own index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Read side bookkeeping, including a write to the address being read.
	always_ff @(posedge clk) begin
		rd_addr_s1  <= req.rd_addr;
		rd_valid_s1 <= valid_q[req.rd_addr];
		hit_s1      <= req.wr_en && (req.wr_addr == req.rd_addr);
		hit_data_s1 <= req.wr_data;
	end

	// The forwarded write wins, then stored data, then the identity value.
	assign rd_data = hit_s1 ? hit_data_s1 : (rd_valid_s1 ? rd_raw_s1 : byte_t'(rd_addr_s1));

endmodule

### rtl/rc4_core.sv
// Item sequencer and index datapath of the RC4 keystream generator.
`include "assert_macros.svh"

module rc4_core import rc4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  byte_t      key_byte,
	output logic       res_req,
	input  logic       res_ack,
	output byte_t      res_data,
	output mem_req_t   mem_req,
	input  byte_t      mem_rd_data
);

	state_t state_q, state_d, start_state;
	logic   accept;

	idx_t  si_q, sj_q, gi_q, gj_q;
	idx_t  gi_inc, j_next, t_next;
	mode_t op_q;
	byte_t key_q, a_q, res_q, res_val;
	idx_t  i_q, j_q, t_q;

	assign accept = in_valid && !in_stall;
	assign gi_inc = idx_t'(gi_q + 1'b1);

	// Accumulator update of the first read, key schedule or generation form.
	assign j_next = (op_q == MODE_KEY) ? idx_t'(sj_q + mem_rd_data + key_q)
	                                   : idx_t'(gj_q + mem_rd_data);
	// Output address is the sum of the two swapped values.
	assign t_next = idx_t'(a_q + mem_rd_data);

	// A later write of the first value to the output address overrides memory.
	assign res_val  = (t_q == j_q) ? a_q : mem_rd_data;
	assign res_data = (state_q == ST_HOLD) ? res_q : res_val;

	always_comb begin
		if (mode inside {MODE_KEY, MODE_GEN}) begin
			start_state = ST_RD_A;
		end else begin
			start_state = ST_IDLE;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = start_state;
				end
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_SWAP;
			ST_SWAP: begin
				if (accept) begin
					state_d = start_state;
				end else if (res_req && !res_ack) begin
					state_d = ST_HOLD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_HOLD: begin
				if (res_ack) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake and memory requests of each state.
	always_comb begin
		in_stall        = 1'b1;
		res_req         = 1'b0;
		mem_req         = '0;
		mem_req.rd_addr = (mode == MODE_KEY) ? si_q : gi_inc;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_RD_A: begin
				mem_req.rd_addr = j_next;
			end
			ST_RD_B: begin
				mem_req.rd_addr = t_next;
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = i_q;
				mem_req.wr_data = mem_rd_data;
			end
			ST_SWAP: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = j_q;
				mem_req.wr_data = a_q;
				res_req         = (op_q == MODE_GEN);
				in_stall        = (op_q == MODE_GEN) && !res_ack;
			end
			ST_HOLD: begin
				res_req = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
		mem_req.clear = accept && (mode == MODE_RESTART);
	end

	// State and index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= MODE_RESTART;
			si_q    <= '0;
			sj_q    <= '0;
			gi_q    <= '0;
			gj_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= mode_t'(mode);
				if (mode == MODE_RESTART) begin
					si_q <= '0;
					sj_q <= '0;
					gi_q <= '0;
					gj_q <= '0;
				end else if (mode == MODE_GEN) begin
					gi_q <= gi_inc;
				end
			end else if (state_q == ST_RD_A) begin
				if (op_q == MODE_KEY) begin
					sj_q <= j_next;
					si_q <= idx_t'(si_q + 1'b1);
				end else begin
					gj_q <= j_next;
				end
			end
		end
	end

	// Per-item word registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_byte;
			i_q   <= (mode == MODE_KEY) ? si_q : gi_inc;
		end
		if (state_q == ST_RD_A) begin
			a_q <= mem_rd_data;
			j_q <= j_next;
		end
		if (state_q == ST_RD_B) begin
			t_q <= t_next;
		end
		if (state_q == ST_SWAP) begin
			res_q <= res_val;
		end
	end

	`ASSERT_IMPL(a_key_no_result, state_q == ST_SWAP && op_q == MODE_KEY, !res_req, "key step gave a word")
	`ASSERT_IMPL(a_wr_states, mem_req.wr_en, state_q == ST_RD_B || state_q == ST_SWAP, "write out of swap")
	`ASSERT_CLK(a_rda_to_rdb, state_q == ST_RD_A |=> state_q == ST_RD_B, "second read skipped")
	`ASSERT_IMPL(a_accept_states, !in_stall, state_q == ST_IDLE || state_q == ST_SWAP, "accept while busy")

endmodule

### rtl/rc4_keystream_generator.sv
// A generate word is registered for out_valid after the RD_A, RD_B and SWAP states.
// Key and generate items pass RD_A, RD_B and SWAP, set by the chain of three dependent
// permutation reads (i, then j, then the output address); restart and unused stay idle.
// A finished word waits in the output register while the next item is already accepted.
// Reset (arst_n low) clears all indices and valid bits at once, so the permutation reads
// as the identity right after reset with no clearing pass; a restart item does the same.
module rc4_keystream_generator import rc4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  byte_t      key_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output byte_t      keystream_byte
);

	mem_req_t mem_req;
	byte_t    mem_rd_data;
	logic     res_req;
	logic     res_ack;
	byte_t    res_data;
	logic     out_valid_q;
	byte_t    out_data_q;

	rc4_perm_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	rc4_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.key_byte    (key_byte),
		.res_req     (res_req),
		.res_ack     (res_ack),
		.res_data    (res_data),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data)
	);

	// The output register takes a new word when empty or being drained.
	assign res_ack = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_req && res_ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_req && res_ack) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid      = out_valid_q;
	assign keystream_byte = out_data_q;

endmodule
